// ----- hdl/bfa_pkg.sv -----
package bfa_pkg;

   // Default geometry of the page bitmap
   localparam int DEF_ROWS      = 16;
   localparam int DEF_ROW_WIDTH = 32;

   // Field widths of the channels
   localparam int ACTION_W    = 2;
   localparam int ROW_INDEX_W = 4;
   localparam int ROW_BITS_W  = 32;
   localparam int REQUEST_W   = 10;
   localparam int STATUS_W    = 2;
   localparam int START_ROW_W = 5;
   localparam int START_COL_W = 6;
   localparam int FREE_W      = 10;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NO_FIT = 2'd1;
   localparam logic [STATUS_W-1:0] STS_ZERO   = 2'd2;

   // Control from the sequencer to the bit-serial unit
   typedef struct packed {
      logic load;
      logic step;
      logic clear_run;
   } serial_ctrl_type;

   // Status from the bit-serial unit back to the sequencer
   typedef struct packed {
      logic old_bit;
      logic new_bit;
      logic last_col;
      logic hit;
   } serial_stat_type;

endpackage

// ----- hdl/bfa_req_if.sv -----
interface bfa_req_if;
   logic                              valid;
   logic                              ready;
   logic [bfa_pkg::ACTION_W-1:0]      action;
   logic [bfa_pkg::ROW_INDEX_W-1:0]   row_index;
   logic [bfa_pkg::ROW_BITS_W-1:0]    row_bits;
   logic [bfa_pkg::REQUEST_W-1:0]     request_count;

   modport source (output valid, action, row_index, row_bits, request_count, input ready);
   modport sink   (input valid, action, row_index, row_bits, request_count, output ready);
endinterface

// ----- hdl/bfa_rsp_if.sv -----
interface bfa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bfa_pkg::STATUS_W-1:0]      status;
   logic [bfa_pkg::START_ROW_W-1:0]   start_row;
   logic [bfa_pkg::START_COL_W-1:0]   start_column;
   logic [bfa_pkg::ROW_BITS_W-1:0]    row_data;
   logic [bfa_pkg::FREE_W-1:0]        free_pages;

   modport source (output valid, status, start_row, start_column, row_data, free_pages,
                   input ready);
   modport sink   (input valid, status, start_row, start_column, row_data, free_pages,
                   output ready);
endinterface

// ----- hdl/bitmap_first_fit_page_allocator_core.sv -----
// Page bitmap allocator, first fit over ROWS rows of ROW_WIDTH pages (0 free, 1 used).
// req_chan carries one item: write a row, read a row, or allocate a run of
// request_count contiguous pages. rsp_chan returns one item per request with
// status, the 1-based start row and column of an allocated run, read data and
// the free page count after the item. Both are valid/ready channels.
// A read goes through S_RD; a write also shifts the old and new row past
// the serial unit, which adjusts the free count one bit per cycle. The
// search for an allocate shifts the bitmap through a one-bit serial unit
// with a carried run counter, one page per cycle apart from a row load
// state between rows; marking rewrites one row per cycle. One item is in
// work at a time; the next is taken once the result sits in the output
// register, so a result waiting on a stalled receiver does not hold back
// the next item's work, only its delivery.
// Reset: all pages free, free count ROWS*ROW_WIDTH, no result pending; the
// block takes items in the cycle after reset drops.
module bitmap_first_fit_page_allocator_core #(
   parameter int ROWS      = bfa_pkg::DEF_ROWS,
   parameter int ROW_WIDTH = bfa_pkg::DEF_ROW_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   bfa_req_if.sink          req_chan,
   bfa_rsp_if.source        rsp_chan
);

   localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(ROW_WIDTH);
   localparam int TOTAL = ROWS * ROW_WIDTH;
   localparam int FW    = $clog2(TOTAL + 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD     = 3'd1;
   localparam logic [2:0] S_WRCNT  = 3'd2;
   localparam logic [2:0] S_SCANLD = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_MARK   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]                          state_ff, state_in;
   logic [FW-1:0]                       free_ff, free_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bfa_pkg::ACTION_W-1:0]        op_ff, op_in;
   logic [bfa_pkg::ROW_BITS_W-1:0]      bits_ff, bits_in;
   logic [bfa_pkg::REQUEST_W-1:0]       req_ff, req_in;
   logic                                in_range_ff, in_range_in;
   logic [RAW-1:0]                      row_ff, row_in;
   logic [RAW-1:0]                      start_row_ff, start_row_in;
   logic [CW-1:0]                       start_col_ff, start_col_in;
   logic [RAW-1:0]                      end_row_ff, end_row_in;
   logic [CW-1:0]                       end_col_ff, end_col_in;
   logic [bfa_pkg::STATUS_W-1:0]        res_status_ff, res_status_in;
   logic [bfa_pkg::START_ROW_W-1:0]     res_srow_ff, res_srow_in;
   logic [bfa_pkg::START_COL_W-1:0]     res_scol_ff, res_scol_in;
   logic [bfa_pkg::ROW_BITS_W-1:0]      res_data_ff, res_data_in;
   logic [bfa_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [bfa_pkg::START_ROW_W-1:0]     rsp_srow_ff, rsp_srow_in;
   logic [bfa_pkg::START_COL_W-1:0]     rsp_scol_ff, rsp_scol_in;
   logic [bfa_pkg::ROW_BITS_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [bfa_pkg::FREE_W-1:0]          rsp_free_ff, rsp_free_in;

   logic                                req_fire;
   logic                                req_in_range;
   logic [ROW_WIDTH-1:0]                rd_row;
   logic                                wr_en;
   logic [ROW_WIDTH-1:0]                wr_row;
   logic [ROW_WIDTH-1:0]                new_row;
   logic [ROW_WIDTH-1:0]                mark_mask;
   bfa_pkg::serial_ctrl_type            ctrl;
   bfa_pkg::serial_stat_type            stat;
   logic [CW-1:0]                       col;
   logic [RAW-1:0]                      first_row;
   logic [CW-1:0]                       first_col;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_in_range   = (32'(req_chan.row_index) < 32'(ROWS));
   assign new_row        = ROW_WIDTH'(bits_ff);

   // Row store; the read address is the next row register value
   bfa_row_store #(
      .ROWS      (ROWS),
      .ROW_WIDTH (ROW_WIDTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (row_in),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_row  (wr_row)
   );

   // Bit-serial scan and free-count unit
   bfa_bit_serial #(
      .ROWS      (ROWS),
      .ROW_WIDTH (ROW_WIDTH)
   ) u_serial (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .row       (row_ff),
      .old_row   (rd_row),
      .new_row   (new_row),
      .request   (req_ff),
      .stat      (stat),
      .col       (col),
      .first_row (first_row),
      .first_col (first_col)
   );

   // Columns of the current row covered by the found run
   always_comb begin
      for (int k = 0; k < ROW_WIDTH; k++) begin
         mark_mask[k] = ((row_ff != start_row_ff) || (CW'(k) >= start_col_ff)) &&
                        ((row_ff != end_row_ff) || (CW'(k) <= end_col_ff));
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      op_in         = op_ff;
      bits_in       = bits_ff;
      req_in        = req_ff;
      in_range_in   = in_range_ff;
      row_in        = row_ff;
      start_row_in  = start_row_ff;
      start_col_in  = start_col_ff;
      end_row_in    = end_row_ff;
      end_col_in    = end_col_ff;
      res_status_in = res_status_ff;
      res_srow_in   = res_srow_ff;
      res_scol_in   = res_scol_ff;
      res_data_in   = res_data_ff;
      wr_en         = 1'b0;
      wr_row        = new_row;
      ctrl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_chan.action;
               bits_in       = req_chan.row_bits;
               req_in        = req_chan.request_count;
               in_range_in   = req_in_range;
               res_status_in = bfa_pkg::STS_OK;
               res_srow_in   = '0;
               res_scol_in   = '0;
               res_data_in   = '0;
               priority if (req_chan.action == bfa_pkg::ACT_WRITE ||
                            req_chan.action == bfa_pkg::ACT_READ) begin
                  row_in   = RAW'(req_chan.row_index);
                  state_in = S_RD;
               end else if (req_chan.action == bfa_pkg::ACT_ALLOC) begin
                  if (req_chan.request_count == '0) begin
                     res_status_in = bfa_pkg::STS_ZERO;
                     state_in      = S_RESP;
                  end else begin
                     ctrl.clear_run = 1'b1;
                     row_in         = '0;
                     state_in       = S_SCANLD;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RD: begin
            // Row data of row_ff is valid now
            if (op_ff == bfa_pkg::ACT_READ) begin
               res_data_in = in_range_ff ? bfa_pkg::ROW_BITS_W'(rd_row) : '0;
               state_in    = S_RESP;
            end else if (in_range_ff) begin
               wr_en     = 1'b1;
               ctrl.load = 1'b1;
               state_in  = S_WRCNT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRCNT: begin
            // Old and new row shift past one bit per cycle
            ctrl.step = 1'b1;
            if (stat.old_bit && !stat.new_bit) begin
               free_in = free_ff + 1'b1;
            end else if (!stat.old_bit && stat.new_bit) begin
               free_in = free_ff - 1'b1;
            end
            if (stat.last_col) begin
               state_in = S_RESP;
            end
         end
         S_SCANLD: begin
            ctrl.load = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            ctrl.step = 1'b1;
            if (stat.hit) begin
               start_row_in = first_row;
               start_col_in = first_col;
               end_row_in   = row_ff;
               end_col_in   = col;
               row_in       = first_row;
               state_in     = S_MARK;
            end else if (stat.last_col) begin
               if (row_ff == RAW'(ROWS - 1)) begin
                  res_status_in = bfa_pkg::STS_NO_FIT;
                  state_in      = S_RESP;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_SCANLD;
               end
            end
         end
         S_MARK: begin
            // Read-modify-write one row of the run per cycle
            wr_en  = 1'b1;
            wr_row = rd_row | mark_mask;
            if (row_ff == end_row_ff) begin
               free_in     = free_ff - FW'(req_ff);
               res_srow_in = bfa_pkg::START_ROW_W'(start_row_ff) + 1'b1;
               res_scol_in = bfa_pkg::START_COL_W'(start_col_ff) + 1'b1;
               state_in    = S_RESP;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register; the free count is captured with the rest of the item
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_srow_in   = rsp_srow_ff;
      rsp_scol_in   = rsp_scol_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_free_in   = rsp_free_ff;
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_srow_in   = res_srow_ff;
         rsp_scol_in   = res_scol_ff;
         rsp_data_in   = res_data_ff;
         rsp_free_in   = bfa_pkg::FREE_W'(free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= FW'(TOTAL);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bits_ff       <= bits_in;
      req_ff        <= req_in;
      in_range_ff   <= in_range_in;
      row_ff        <= row_in;
      start_row_ff  <= start_row_in;
      start_col_ff  <= start_col_in;
      end_row_ff    <= end_row_in;
      end_col_ff    <= end_col_in;
      res_status_ff <= res_status_in;
      res_srow_ff   <= res_srow_in;
      res_scol_ff   <= res_scol_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_srow_ff   <= rsp_srow_in;
      rsp_scol_ff   <= rsp_scol_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.start_row    = rsp_srow_ff;
   assign rsp_chan.start_column = rsp_scol_ff;
   assign rsp_chan.row_data     = rsp_data_ff;
   assign rsp_chan.free_pages   = rsp_free_ff;

   // A new result appears only out of the result state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result raised outside the result state");

   // Free count never exceeds the bitmap size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FW'(TOTAL))
      else $error("free page count above total");

   // A run match always leads into marking
   a_hit_marks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && stat.hit |=> state_ff == S_MARK)
      else $error("run found but marking not started");

   // Marking stays within the rows of the found run
   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> row_ff >= start_row_ff && row_ff <= end_row_ff)
      else $error("marking outside the found run");

endmodule

// ----- hdl/bfa_row_store.sv -----
module bfa_row_store #(
   parameter int ROWS      = bfa_pkg::DEF_ROWS,
   parameter int ROW_WIDTH = bfa_pkg::DEF_ROW_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
   output logic [ROW_WIDTH-1:0]                rd_row,
   input  logic                                wr_en,
   input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_addr,
   input  logic [ROW_WIDTH-1:0]                wr_row
);

   logic [ROW_WIDTH-1:0] mem [ROWS];
   logic [ROW_WIDTH-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [ROWS-1:0]      valid_ff;

   // Row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Per-row written flags; an unwritten row reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/bfa_bit_serial.sv -----
module bfa_bit_serial #(
   parameter int ROWS      = bfa_pkg::DEF_ROWS,
   parameter int ROW_WIDTH = bfa_pkg::DEF_ROW_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bfa_pkg::serial_ctrl_type                 ctrl,
   input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] row,
   input  logic [ROW_WIDTH-1:0]                     old_row,
   input  logic [ROW_WIDTH-1:0]                     new_row,
   input  logic [bfa_pkg::REQUEST_W-1:0]            request,
   output bfa_pkg::serial_stat_type                 stat,
   output logic [$clog2(ROW_WIDTH)-1:0]             col,
   output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] first_row,
   output logic [$clog2(ROW_WIDTH)-1:0]             first_col
);

   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW   = $clog2(ROW_WIDTH);
   localparam int RUNW = $clog2(ROWS * ROW_WIDTH + 1);
   localparam int CMPW = (RUNW > bfa_pkg::REQUEST_W) ? RUNW : bfa_pkg::REQUEST_W;

   logic [ROW_WIDTH-1:0] old_sh_ff, old_sh_in;
   logic [ROW_WIDTH-1:0] new_sh_ff, new_sh_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RUNW-1:0]      run_ff, run_in;
   logic [RUNW-1:0]      run_inc;
   logic [RAW-1:0]       first_row_ff, first_row_in;
   logic [CW-1:0]        first_col_ff, first_col_in;

   // Current bit and run match
   assign run_inc       = run_ff + 1'b1;
   assign stat.old_bit  = old_sh_ff[0];
   assign stat.new_bit  = new_sh_ff[0];
   assign stat.last_col = (col_ff == CW'(ROW_WIDTH - 1));
   assign stat.hit      = !old_sh_ff[0] && (CMPW'(run_inc) == CMPW'(request));

   // A run that begins at this bit starts here
   assign col       = col_ff;
   assign first_row = (run_ff == '0) ? row : first_row_ff;
   assign first_col = (run_ff == '0) ? col_ff : first_col_ff;

   // Next-state logic: load a row, or consume one bit
   always_comb begin
      old_sh_in    = old_sh_ff;
      new_sh_in    = new_sh_ff;
      col_in       = col_ff;
      run_in       = run_ff;
      first_row_in = first_row_ff;
      first_col_in = first_col_ff;
      if (ctrl.load) begin
         old_sh_in = old_row;
         new_sh_in = new_row;
         col_in    = '0;
      end else if (ctrl.step) begin
         old_sh_in = old_sh_ff >> 1;
         new_sh_in = new_sh_ff >> 1;
         col_in    = col_ff + 1'b1;
         if (old_sh_ff[0]) begin
            run_in = '0;
         end else begin
            run_in       = run_inc;
            first_row_in = first_row;
            first_col_in = first_col;
         end
      end
      if (ctrl.clear_run) begin
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      old_sh_ff    <= old_sh_in;
      new_sh_ff    <= new_sh_in;
      col_ff       <= col_in;
      first_row_ff <= first_row_in;
      first_col_ff <= first_col_in;
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

   localparam int NROWS = bfa_pkg::DEF_ROWS;
   localparam int NCOLS = bfa_pkg::DEF_ROW_WIDTH;
   localparam int NPAGES = NROWS * NCOLS;

   // Action code 3 has no meaning in the block; it must change nothing
   localparam logic [bfa_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Allocate of a full bitmap scan plus memory reads, rounded up
   localparam int DRAIN_CYCLES = 700;

   typedef struct packed {
      logic [bfa_pkg::ACTION_W-1:0]    action;
      logic [bfa_pkg::ROW_INDEX_W-1:0] row_index;
      logic [bfa_pkg::ROW_BITS_W-1:0]  row_bits;
      logic [bfa_pkg::REQUEST_W-1:0]   request_count;
   } page_item_type;

   typedef struct packed {
      logic [bfa_pkg::STATUS_W-1:0]    status;
      logic [bfa_pkg::START_ROW_W-1:0] start_row;
      logic [bfa_pkg::START_COL_W-1:0] start_column;
      logic [bfa_pkg::ROW_BITS_W-1:0]  row_data;
      logic [bfa_pkg::FREE_W-1:0]      free_pages;
   } page_result_type;

   logic clock;
   logic reset;

   bfa_req_if req_ch ();
   bfa_rsp_if rsp_ch ();

   bitmap_first_fit_page_allocator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch)
   );

   // Shadow copy of the allocator state
   logic [NCOLS-1:0] shadow_bitmap [NROWS];
   int               shadow_free;

   page_result_type expected_results [$];
   int              error_count;
   bit              sender_idle;
   bit              receiver_idle;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_error(input string msg);
      if (error_count < 100)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Expected outcome of one accepted item; updates the shadow state
   function automatic page_result_type predict_page_result(input page_item_type it);
      page_result_type r;
      int run;
      int start;
      bit found;
      r = '0;
      run = 0;
      start = 0;
      found = 1'b0;
      unique case (it.action)
         bfa_pkg::ACT_WRITE: begin
            shadow_free = shadow_free - (NCOLS - $countones(shadow_bitmap[it.row_index]))
                          + (NCOLS - $countones(it.row_bits));
            shadow_bitmap[it.row_index] = it.row_bits;
         end
         bfa_pkg::ACT_READ: begin
            r.row_data = shadow_bitmap[it.row_index];
         end
         bfa_pkg::ACT_ALLOC: begin
            if (it.request_count == '0) begin
               r.status = bfa_pkg::STS_ZERO;
            end else begin
               // first fit in linear page order, runs carried across rows
               for (int p = 0; p < NPAGES && !found; p++) begin
                  if (shadow_bitmap[p / NCOLS][p % NCOLS]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == int'(it.request_count)) begin
                        start = p + 1 - run;
                        found = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  r.status = bfa_pkg::STS_NO_FIT;
               end else begin
                  for (int p = start; p < start + int'(it.request_count); p++)
                     shadow_bitmap[p / NCOLS][p % NCOLS] = 1'b1;
                  shadow_free -= int'(it.request_count);
                  r.start_row    = bfa_pkg::START_ROW_W'(start / NCOLS + 1);
                  r.start_column = bfa_pkg::START_COL_W'(start % NCOLS + 1);
               end
            end
         end
         default: ;
      endcase
      r.free_pages = bfa_pkg::FREE_W'(shadow_free);
      return r;
   endfunction

   // Drive one item and wait for it to be taken
   task automatic send_item(input page_item_type it);
      int gap;
      @(negedge clock);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= it.action;
      req_ch.row_index     <= it.row_index;
      req_ch.row_bits      <= it.row_bits;
      req_ch.request_count <= it.request_count;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(predict_page_result(it));
   endtask

   task automatic send_op(input logic [bfa_pkg::ACTION_W-1:0] action,
                          input logic [bfa_pkg::ROW_INDEX_W-1:0] row_index,
                          input logic [bfa_pkg::ROW_BITS_W-1:0] row_bits,
                          input logic [bfa_pkg::REQUEST_W-1:0] request_count);
      page_item_type it;
      it = '{action, row_index, row_bits, request_count};
      send_item(it);
   endtask

   // Result checker
   always @(posedge clock) begin
      page_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_error("result item with no item outstanding");
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_ch.status !== exp_r.status)
               report_error($sformatf("status got %0d exp %0d",
                                      rsp_ch.status, exp_r.status));
            if (rsp_ch.start_row !== exp_r.start_row)
               report_error($sformatf("start_row got %0d exp %0d",
                                      rsp_ch.start_row, exp_r.start_row));
            if (rsp_ch.start_column !== exp_r.start_column)
               report_error($sformatf("start_column got %0d exp %0d",
                                      rsp_ch.start_column, exp_r.start_column));
            if (rsp_ch.row_data !== exp_r.row_data)
               report_error($sformatf("row_data got %h exp %h",
                                      rsp_ch.row_data, exp_r.row_data));
            if (rsp_ch.free_pages !== exp_r.free_pages)
               report_error($sformatf("free_pages got %0d exp %0d",
                                      rsp_ch.free_pages, exp_r.free_pages));
         end
      end
   end

   // Receiver back-pressure in random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Random row contents, biased toward mostly free rows
   function automatic logic [bfa_pkg::ROW_BITS_W-1:0] random_row_bits();
      unique case ($urandom_range(0, 5))
         0, 4: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom & $urandom & $urandom;
         default: return 32'h1 << $urandom_range(0, NCOLS - 1);
      endcase
   endfunction

   // Random run length, mostly short
   function automatic logic [bfa_pkg::REQUEST_W-1:0] random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return bfa_pkg::REQUEST_W'($urandom_range(1, 8));
      else if (pick < 80) return bfa_pkg::REQUEST_W'($urandom_range(9, 40));
      else if (pick < 90) return bfa_pkg::REQUEST_W'($urandom_range(41, NPAGES));
      else if (pick < 95) return '0;
      else return bfa_pkg::REQUEST_W'($urandom_range(NPAGES + 1, 1023));
   endfunction

   function automatic page_item_type random_item();
      page_item_type it;
      int pick;
      // unused fields stay random as noise
      it.row_index     = bfa_pkg::ROW_INDEX_W'($urandom_range(0, NROWS - 1));
      it.row_bits      = $urandom;
      it.request_count = bfa_pkg::REQUEST_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         it.action   = bfa_pkg::ACT_WRITE;
         it.row_bits = random_row_bits();
      end else if (pick < 75) begin
         it.action        = bfa_pkg::ACT_ALLOC;
         it.request_count = random_request();
      end else if (pick < 95) begin
         it.action = bfa_pkg::ACT_READ;
      end else begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   // Tests
   task automatic test_reset_state();
      send_op(bfa_pkg::ACT_READ, 4'd0, '1, '1);
      send_op(bfa_pkg::ACT_READ, 4'd15, '0, '0);
   endtask

   task automatic test_zero_and_oversize();
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd0);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd513);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd1023);
   endtask

   task automatic test_whole_bitmap();
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd512);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd1);
      send_op(bfa_pkg::ACT_READ, 4'd9, '0, '0);
   endtask

   task automatic test_row_boundaries();
      send_op(bfa_pkg::ACT_WRITE, 4'd0, 32'h0000_0000, '0);
      send_op(bfa_pkg::ACT_WRITE, 4'd15, 32'h8000_0000, '0);
      send_op(bfa_pkg::ACT_WRITE, 4'd2, 32'h0000_FFFF, '0);
      send_op(bfa_pkg::ACT_WRITE, 4'd3, 32'hFFFF_0000, '0);
      // exact row, then a run that crosses from row 2 into row 3
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd32);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd32);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd31);
      // only the very last page free
      send_op(bfa_pkg::ACT_WRITE, 4'd15, 32'h7FFF_FFFF, '0);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd1);
      // isolated free pages, no run of two anywhere
      send_op(bfa_pkg::ACT_WRITE, 4'd5, 32'hAAAA_AAAA, '0);
      send_op(bfa_pkg::ACT_WRITE, 4'd6, 32'h5555_5555, '0);
      send_op(bfa_pkg::ACT_ALLOC, 4'd0, '0, 10'd2);
      send_op(bfa_pkg::ACT_READ, 4'd5, '0, '0);
   endtask

   task automatic test_unused_action();
      send_op(ACT_UNUSED, 4'd15, '1, '1);
      send_op(ACT_UNUSED, 4'd0, '0, 10'd1);
   endtask

   task automatic test_random_traffic(input int n);
      for (int i = 0; i < n; i++)
         send_item(random_item());
   endtask

   // Main sequence
   initial begin
      int waited;
      error_count   = 0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      foreach (shadow_bitmap[r]) shadow_bitmap[r] = '0;
      shadow_free = NPAGES;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.action        = bfa_pkg::ACT_WRITE;
      req_ch.row_index     = '0;
      req_ch.row_bits      = '0;
      req_ch.request_count = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_zero_and_oversize();
      test_whole_bitmap();
      test_row_boundaries();
      test_unused_action();
      test_random_traffic(900);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      test_random_traffic(150);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d result items never arrived", expected_results.size()));

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
